>>> rtl/core/rcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, register codes and table functions for the cavity field block.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int COS_DEPTH_DEF = 1024;
  localparam int EXP_DEPTH_DEF = 256;
  localparam int Q16_ONE       = 65536;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE   = 3'd0,
    REG_TIME_STEP   = 3'd1,
    REG_SPACE_STEP  = 3'd2,
    REG_PHASE_OFS   = 3'd3,
    REG_Z_START     = 3'd4,
    REG_Z_END       = 3'd5,
    REG_RADIUS      = 3'd6,
    REG_EDGE_WIDTH  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [23:0] x_pos;
    logic signed [23:0] y_pos;
    logic signed [23:0] z_pos;
    logic [47:0]        time_ps;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] ez_field;
    logic               inside_res;
  } out_item_t;

  // travels alongside the dividers
  typedef struct packed {
    logic signed [17:0] cs;
    logic signed [17:0] ct;
    logic               in_cav;
    logic               full;
    logic               r2z;
  } side_t;

  // cos of a quarter-turn fraction u (0..2^30), Q1.16
  function automatic logic signed [17:0] cos_quarter(input logic [63:0] u);
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      r;
    th   = (u * TWO_PI_Q30) >> 32;
    x2   = (th * th) >> 30;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 8192) >>> 14;
    if (r > Q16_ONE) r = Q16_ONE;
    return 18'(r);
  endfunction

  // p is the turn fraction of the entry, 2^32 scale
  function automatic logic signed [17:0] cos_entry(input logic [63:0] p);
    logic [1:0]  q;
    logic [63:0] rm;
    logic signed [17:0] c;
    q  = p[31:30];
    rm = p & 64'h3FFF_FFFF;
    case (q)
      2'd0:    c = cos_quarter(rm);
      2'd1:    c = -cos_quarter(Q30_ONE - rm);
      2'd2:    c = -cos_quarter(rm);
      default: c = cos_quarter(Q30_ONE - rm);
    endcase
    return c;
  endfunction

  // exp(-x) with x in Q30, Q1.16
  function automatic logic [16:0] exp_entry(input logic [63:0] x);
    logic [63:0] term;
    longint      sum;
    longint      r;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (int n = 1; n <= 24; n++) begin
      term = ((term * x) >> 30) / 64'(n);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 8192) >>> 14;
    if (r > Q16_ONE) r = Q16_ONE;
    return 17'(r);
  endfunction

endpackage

>>> rtl/core/rf_cavity_axial_field_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_cavity_axial_field_eval
// Standing-wave cavity Ez evaluator: table cosines, ramp, Gaussian radial term.
// ----------------------------------------------------------------------------
//  channel | ports                        | carries
//  in      | in_valid, in_ready, in_data  | x, y, z (um), time (ps)
//  out     | out_valid, out_ready, out_data| ez_field, inside_res
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
//  One item per cycle while no result is held. Both dividers are LAT deep,
//  the larger of 16 ramp bits and clog2(EXP_TABLE_DEPTH+1).
//  Synchronous active-low reset clears valid bits and loads register defaults.
//  A held result freezes the whole pipeline; in_ready is low only then.
// ----------------------------------------------------------------------------
module rf_cavity_axial_field_eval
  import rcf_pkg::*;
#(
  parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(COS_TABLE_DEPTH);
  localparam int EQW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int LAT = (EQW > 16) ? EQW : 16;
  localparam int EDW = 46;

  // registers
  logic [30:0]        amp_r;
  logic [31:0]        tps_r, sps_r, ofs_r;
  logic signed [23:0] zs_r, ze_r;
  logic [22:0]        rl_r, ew_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= 31'd1000000;
      tps_r <= 32'd12266427;
      sps_r <= 32'd40917;
      ofs_r <= 32'd0;
      zs_r  <= 24'sd3250000;
      ze_r  <= 24'sd3750000;
      rl_r  <= 23'd400000;
      ew_r  <= 23'd50000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMPLITUDE:  amp_r <= cfg_data[30:0];
        REG_TIME_STEP:  tps_r <= cfg_data;
        REG_SPACE_STEP: sps_r <= cfg_data;
        REG_PHASE_OFS:  ofs_r <= cfg_data;
        REG_Z_START:    zs_r  <= cfg_data[23:0];
        REG_Z_END:      ze_r  <= cfg_data[23:0];
        REG_RADIUS:     rl_r  <= cfg_data[22:0];
        REG_EDGE_WIDTH: ew_r  <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // tables
  logic signed [17:0] cos_rom [COS_TABLE_DEPTH];
  logic [16:0]        exp_rom [EXP_TABLE_DEPTH+1];

  for (genvar i = 0; i < COS_TABLE_DEPTH; i++) begin : g_cos
    localparam logic [63:0] P = (64'(i) << 32) / 64'(COS_TABLE_DEPTH);
    assign cos_rom[i] = cos_entry(P);
  end

  for (genvar i = 0; i <= EXP_TABLE_DEPTH; i++) begin : g_exp
    localparam logic [63:0] X = (64'(i) << 31) / 64'(EXP_TABLE_DEPTH);
    assign exp_rom[i] = exp_entry(X);
  end

  // pipeline control
  logic en;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [LAT-1:0] vd_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vd_r        <= '0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      vd_r        <= {vd_r[LAT-2:0], v2_r};
      v3_r        <= vd_r[LAT-1];
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // stage 1: squares, z tests, phase products
  logic signed [25:0] z26, zs26, ze26, w26;
  logic signed [24:0] dz;
  logic signed [25:0] dze;
  logic               st_in, en_in;
  logic [47:0]        xx_nxt, yy_nxt;
  logic [45:0]        rr_nxt;
  logic [31:0]        phs_nxt, pt_nxt;

  logic [47:0] xx_r, yy_r;
  logic [45:0] rr_r;
  logic [31:0] phs_r, pt_r;
  logic        zin_r, full1_r;
  logic [22:0] rnum_r;

  always_comb begin
    z26     = {{2{in_data.z_pos[23]}}, in_data.z_pos};
    zs26    = {{2{zs_r[23]}}, zs_r};
    ze26    = {{2{ze_r[23]}}, ze_r};
    w26     = {3'b000, ew_r};
    dz      = 25'(z26 - zs26);
    dze     = ze26 - z26;
    st_in   = z26 < zs26 + w26;
    en_in   = z26 > ze26 - w26;
    xx_nxt  = 48'($signed(in_data.x_pos) * $signed(in_data.x_pos));
    yy_nxt  = 48'($signed(in_data.y_pos) * $signed(in_data.y_pos));
    rr_nxt  = 46'(rl_r) * 46'(rl_r);
    phs_nxt = sps_r * 32'($unsigned({{7{dz[24]}}, dz}));
    pt_nxt  = tps_r * in_data.time_ps[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r    <= xx_nxt;
      yy_r    <= yy_nxt;
      rr_r    <= rr_nxt;
      phs_r   <= phs_nxt;
      pt_r    <= pt_nxt;
      zin_r   <= !(z26 < zs26) && !(z26 > ze26);
      full1_r <= (ew_r == '0) || (!st_in && !en_in);
      rnum_r  <= st_in ? dz[22:0] : dze[22:0];
    end
  end

  // stage 2: radius test, table indexes, divider operands
  logic [48:0]       r2_nxt;
  logic [CW+32:0]    ps_prod, pt_prod;
  logic [31:0]       pht;

  logic [CW-1:0]     cis_r, cit_r;
  logic              in2_r, full2_r, r2z2_r;
  logic [EDW+EQW-1:0] enum_r;
  logic [45:0]       eden_r;
  logic [38:0]       rnum2_r;

  always_comb begin
    r2_nxt  = 49'(xx_r) + 49'(yy_r);
    pht     = pt_r + ofs_r;
    ps_prod = (CW+33)'(phs_r) * (CW+33)'(COS_TABLE_DEPTH);
    pt_prod = (CW+33)'(pht) * (CW+33)'(COS_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cis_r   <= ps_prod[CW+31:32];
      cit_r   <= pt_prod[CW+31:32];
      in2_r   <= zin_r && (r2_nxt <= 49'(rr_r));
      full2_r <= full1_r;
      r2z2_r  <= (rr_r == '0);
      enum_r  <= (EDW+EQW)'(r2_nxt[45:0]) * (EDW+EQW)'(EXP_TABLE_DEPTH);
      eden_r  <= rr_r;
      rnum2_r <= {rnum_r, 16'h0000};
    end
  end

  // dividers and matching sideband line
  logic [15:0]  zq;
  logic [EQW-1:0] eq;

  rcf_div #(.DW(23), .QW(16), .LAT(LAT)) u_ramp_div (
    .clk (clk),
    .en  (en),
    .num (rnum2_r),
    .den (ew_r),
    .quo (zq)
  );

  rcf_div #(.DW(EDW), .QW(EQW), .LAT(LAT)) u_exp_div (
    .clk (clk),
    .en  (en),
    .num (enum_r),
    .den (eden_r),
    .quo (eq)
  );

  side_t side_r [LAT];
  side_t side_in;

  always_comb begin
    side_in.cs     = cos_rom[cis_r];
    side_in.ct     = cos_rom[cit_r];
    side_in.in_cav = in2_r;
    side_in.full   = full2_r;
    side_in.r2z    = r2z2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  // stage 3: factor pairs
  side_t              sd;
  logic [EQW-1:0]     eidx;
  logic [16:0]        zf, rf;
  logic signed [35:0] p1;
  logic [33:0]        p2;
  logic signed [17:0] g1_r;
  logic [16:0]        g2_r;
  logic               in3_r;

  always_comb begin
    sd = side_r[LAT-1];
    if (sd.r2z) eidx = '0;
    else if (eq > EQW'(EXP_TABLE_DEPTH)) eidx = EQW'(EXP_TABLE_DEPTH);
    else eidx = eq;
    zf = sd.full ? 17'(Q16_ONE) : {1'b0, zq};
    rf = exp_rom[eidx];
    p1 = sd.cs * sd.ct;
    p2 = 34'(zf) * 34'(rf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r  <= 18'((p1 + 36'sd32768) >>> 16);
      g2_r  <= 17'((p2 + 34'd32768) >> 16);
      in3_r <= sd.in_cav;
    end
  end

  // stage 4: combined factor
  logic signed [35:0] p3;
  logic signed [17:0] g_r;
  logic               in4_r;

  assign p3 = g1_r * $signed({1'b0, g2_r});

  always_ff @(posedge clk) begin
    if (en) begin
      g_r   <= 18'((p3 + 36'sd32768) >>> 16);
      in4_r <= in3_r;
    end
  end

  // stage 5: amplitude, saturation, output register
  logic signed [49:0] p4;
  logic signed [33:0] ez34;
  out_item_t          res_nxt;
  out_item_t          out_r;

  always_comb begin
    p4   = $signed({1'b0, amp_r}) * g_r;
    ez34 = 34'((p4 + 50'sd32768) >>> 16);
    res_nxt.inside_res = in4_r;
    if (!in4_r) res_nxt.ez_field = '0;
    else if (ez34 > 34'sd2147483647) res_nxt.ez_field = 32'sh7FFF_FFFF;
    else if (ez34 < -34'sd2147483648) res_nxt.ez_field = 32'sh8000_0000;
    else res_nxt.ez_field = ez34[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/rcf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_div
// Pipelined restoring divider, one quotient bit per stage, padded to LAT.
// ----------------------------------------------------------------------------
module rcf_div #(
  parameter int DW  = 23,
  parameter int QW  = 16,
  parameter int LAT = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  localparam int RW = DW + QW;

  logic [RW-1:0] rem_r [LAT];
  logic [DW-1:0] den_r [LAT];
  logic [QW-1:0] quo_r [LAT];

  for (genvar k = 0; k < LAT; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    if (k < QW) begin : g_step
      localparam int B = QW - 1 - k;
      logic [RW-1:0] dsh;
      assign dsh = RW'(den_in) << B;
      always_comb begin
        rem_nxt = rem_in;
        quo_nxt = quo_in;
        if (rem_in >= dsh) begin
          rem_nxt  = rem_in - dsh;
          quo_nxt[B] = 1'b1;
        end
      end
    end else begin : g_pad
      assign rem_nxt = rem_in;
      assign quo_nxt = quo_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[LAT-1];

endmodule
